// File: src/assert_macros.svh
// Assertion helpers shared by the RTL. Clock and reset names are the house ones.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/sle_pkg.sv
`default_nettype none

package sle_pkg;

   // Line buffer geometry
   localparam int LINE_BYTES = 16;
   localparam int FILL_W     = $clog2(LINE_BYTES + 1);
   localparam int LADDR_W    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   localparam int IDX_W      = (FILL_W > 4) ? FILL_W : 4;

   // Character pair
   localparam int CHAR_W = 7;

   // Fixed S0 header record, eight pairs before CR LF
   localparam int               HDR_PAIRS = 8;
   localparam logic [127:0]     HDR_TEXT  = "S00600004844521B";
   localparam logic [CHAR_W-1:0] CH_S  = 7'h53;
   localparam logic [CHAR_W-1:0] CH_CR = 7'h0d;
   localparam logic [CHAR_W-1:0] CH_LF = 7'h0a;

   // Opcodes on the request side
   localparam logic [1:0] OP_SET_ADDR = 2'd0;
   localparam logic [1:0] OP_DATA     = 2'd1;
   localparam logic [1:0] OP_FINISH   = 2'd2;

   // Record kinds
   typedef enum logic [1:0] {
      REC_S1,
      REC_S5,
      REC_S9
   } rec_type;

   // Sequencer steps
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR,
      ST_TAG,
      ST_CNT,
      ST_AHI,
      ST_ALO,
      ST_DATA,
      ST_SUM,
      ST_END
   } state_type;

   // One emitted character pair
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] first;
      logic [CHAR_W-1:0] second;
      logic              last;
   } pair_type;

   // Line buffer access
   typedef struct packed {
      logic               we;
      logic [LADDR_W-1:0] waddr;
      logic [7:0]         wdata;
      logic               re;
      logic [LADDR_W-1:0] raddr;
   } ram_req_type;

   // Sequencer status seen by the top level
   typedef struct packed {
      logic              idle;
      logic [FILL_W-1:0] fill;
   } seq_status_type;

   // Upper-case hex digit
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return 7'h30 + {3'b000, v};
      end
      return 7'h37 + {3'b000, v};
   endfunction

   // Header pair i as {first, second}
   function automatic logic [2*CHAR_W-1:0] hdr_pair(input logic [2:0] i);
      logic [127:0] sh;
      sh = HDR_TEXT >> (16 * (7 - int'(i)));
      return {sh[14:8], sh[6:0]};
   endfunction

   // Second character of the record tag
   function automatic logic [CHAR_W-1:0] tag_char(input rec_type k);
      case (k)
         REC_S1:  return 7'h31;
         REC_S5:  return 7'h35;
         default: return 7'h39;
      endcase
   endfunction

endpackage

`default_nettype wire

// File: src/sle_line_ram.sv
`default_nettype none

module sle_line_ram
   import sle_pkg::*;
(
   input  wire logic        clock,
   input  wire ram_req_type ram_req,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [LINE_BYTES];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // Registered read port, holds while re is low
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/sle_record_seq.sv
`default_nettype none

module sle_record_seq
   import sle_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic [1:0]     req_opcode,
   input  wire logic [15:0]    req_operand,
   output logic                req_ready,
   input  wire logic           slot_free,
   input  wire logic [7:0]     rd_data,
   output ram_req_type         ram_req,
   output pair_type            pair,
   output seq_status_type      status
);

   state_type         state_ff, state_in;
   rec_type           kind_ff, kind_in;
   logic [1:0]        op_ff, op_in;
   logic [15:0]       arg_ff, arg_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       line_start_ff, line_start_in;
   logic [15:0]       rec_count_ff, rec_count_in;
   logic              hdr_sent_ff, hdr_sent_in;
   logic [7:0]        sum_ff, sum_in;

   logic             accept;
   logic             fire;
   logic             jump;
   logic [IDX_W-1:0] idx_next;
   logic [15:0]      word;
   logic [7:0]       byte_val;
   logic             is_byte;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign fire     = (state_ff != ST_IDLE) && slot_free;
   assign idx_next = idx_ff + IDX_W'(1);
   assign jump     = ({1'b0, line_start_ff} + 17'(fill_ff)) != {1'b0, req_operand};

   assign req_ready   = (state_ff == ST_IDLE);
   assign status.idle = (state_ff == ST_IDLE);
   assign status.fill = fill_ff;

   // Address word of the current record
   always_comb begin
      case (kind_ff)
         REC_S1:  word = line_start_ff;
         REC_S5:  word = rec_count_ff;
         default: word = arg_ff;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_SET_ADDR: begin
                     if (jump && (fill_ff != '0)) begin
                        state_in = hdr_sent_ff ? ST_TAG : ST_HDR;
                        kind_in  = REC_S1;
                     end
                  end
                  OP_DATA: begin
                     if ((fill_ff + FILL_W'(1)) == FILL_W'(LINE_BYTES)) begin
                        state_in = hdr_sent_ff ? ST_TAG : ST_HDR;
                        kind_in  = REC_S1;
                     end
                  end
                  OP_FINISH: begin
                     if (fill_ff != '0) begin
                        state_in = hdr_sent_ff ? ST_TAG : ST_HDR;
                        kind_in  = REC_S1;
                     end else begin
                        state_in = ST_TAG;
                        kind_in  = REC_S5;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_HDR: begin
            if (fire && (idx_ff == IDX_W'(HDR_PAIRS))) begin
               state_in = ST_TAG;
            end
         end
         ST_TAG: if (fire) state_in = ST_CNT;
         ST_CNT: if (fire) state_in = ST_AHI;
         ST_AHI: if (fire) state_in = ST_ALO;
         ST_ALO: begin
            if (fire) begin
               state_in = (kind_ff == REC_S1) ? ST_DATA : ST_SUM;
            end
         end
         ST_DATA: begin
            if (fire && (idx_next == IDX_W'(fill_ff))) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: if (fire) state_in = ST_END;
         ST_END: begin
            if (fire) begin
               case (kind_ff)
                  REC_S1: begin
                     if (op_ff == OP_FINISH) begin
                        state_in = ST_TAG;
                        kind_in  = REC_S5;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  REC_S5: begin
                     state_in = ST_TAG;
                     kind_in  = REC_S9;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Pair generation and datapath updates
   always_comb begin
      op_in         = op_ff;
      arg_in        = arg_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      line_start_in = line_start_ff;
      rec_count_in  = rec_count_ff;
      hdr_sent_in   = hdr_sent_ff;
      sum_in        = sum_ff;
      ram_req       = '0;
      pair          = '0;
      byte_val      = '0;
      is_byte       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               op_in  = req_opcode;
               arg_in = req_operand;
               case (req_opcode)
                  OP_SET_ADDR: begin
                     if (jump && (fill_ff == '0)) begin
                        line_start_in = req_operand;
                     end
                  end
                  OP_DATA: begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = fill_ff[LADDR_W-1:0];
                     ram_req.wdata = req_operand[7:0];
                     fill_in       = fill_ff + FILL_W'(1);
                  end
                  default: op_in = req_opcode;
               endcase
            end
         end
         ST_HDR: begin
            if (idx_ff == IDX_W'(HDR_PAIRS)) begin
               pair.first  = CH_CR;
               pair.second = CH_LF;
               if (fire) begin
                  hdr_sent_in = 1'b1;
               end
            end else begin
               {pair.first, pair.second} = hdr_pair(idx_ff[2:0]);
            end
         end
         ST_TAG: begin
            pair.first  = CH_S;
            pair.second = tag_char(kind_ff);
         end
         ST_CNT: begin
            is_byte  = 1'b1;
            byte_val = (kind_ff == REC_S1) ? (8'(fill_ff) + 8'd3) : 8'd3;
         end
         ST_AHI: begin
            is_byte  = 1'b1;
            byte_val = word[15:8];
         end
         ST_ALO: begin
            is_byte  = 1'b1;
            byte_val = word[7:0];
            // prefetch first line byte
            if (fire && (kind_ff == REC_S1)) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = '0;
            end
         end
         ST_DATA: begin
            is_byte  = 1'b1;
            byte_val = rd_data;
            if (fire && (idx_next < IDX_W'(fill_ff))) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = idx_next[LADDR_W-1:0];
            end
         end
         ST_SUM: begin
            is_byte  = 1'b1;
            byte_val = ~sum_ff;
         end
         ST_END: begin
            pair.first  = CH_CR;
            pair.second = CH_LF;
            pair.last   = (kind_ff == REC_S9) ||
                          ((kind_ff == REC_S1) && (op_ff != OP_FINISH));
            // line retired: advance start, count the record
            if (fire && (kind_ff == REC_S1)) begin
               fill_in       = '0;
               rec_count_in  = rec_count_ff + 16'd1;
               line_start_in = (op_ff == OP_SET_ADDR) ? arg_ff
                             : (line_start_ff + 16'(fill_ff));
            end
         end
         default: pair = '0;
      endcase

      // hex pair for byte steps
      if (is_byte) begin
         pair.first  = hex_char(byte_val[7:4]);
         pair.second = hex_char(byte_val[3:0]);
      end

      if (fire) begin
         pair.valid = 1'b1;
         if ((state_ff == ST_HDR) || (state_ff == ST_DATA)) begin
            idx_in = idx_next;
         end else begin
            idx_in = '0;
         end
         if (state_ff == ST_TAG) begin
            sum_in = '0;
         end else if (is_byte) begin
            sum_in = sum_ff + byte_val;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kind_ff       <= REC_S1;
         idx_ff        <= '0;
         fill_ff       <= '0;
         line_start_ff <= '0;
         rec_count_ff  <= '0;
         hdr_sent_ff   <= 1'b0;
         sum_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         kind_ff       <= kind_in;
         idx_ff        <= idx_in;
         fill_ff       <= fill_in;
         line_start_ff <= line_start_in;
         rec_count_ff  <= rec_count_in;
         hdr_sent_ff   <= hdr_sent_in;
         sum_ff        <= sum_in;
      end
   end

   // Held request payload
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      arg_ff <= arg_in;
   end

endmodule

`default_nettype wire

// File: src/srecord_line_emitter.sv
`default_nettype none
`include "assert_macros.svh"

// S-record line emitter. Each request beat carries an opcode in req_tuser
// (set address, append byte, finish) and a 16-bit operand in req_tdata; the
// block answers with upper-case ASCII character pairs, rsp_tlast on the last
// pair caused by a request. An append that does not fill the line yields
// nothing. A request that flushes a line of N bytes emits N+6 pairs (plus 9
// for the S0 header before the first S1), and finish adds 12 more for S5 and
// S9; the record sequencer produces one pair per cycle while the output
// register is free and takes the next request in the cycle after its last
// pair is produced. Line bytes sit in a 16-entry buffer with a registered
// read port, read ahead of use.

module srecord_line_emitter
   import sle_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] operand
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [6:0] char_first, [13:7] char_second, [15:14] zero
   output logic             rsp_tlast
);

   ram_req_type    ram_req;
   pair_type       pair;
   seq_status_type status;
   logic [7:0]     rd_data;
   logic           slot_free;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [CHAR_W-1:0] first_ff, first_in;
   logic [CHAR_W-1:0] second_ff, second_in;
   logic              last_ff, last_in;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   sle_record_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_opcode  (req_tuser),
      .req_operand (req_tdata),
      .req_ready   (req_tready),
      .slot_free   (slot_free),
      .rd_data     (rd_data),
      .ram_req     (ram_req),
      .pair        (pair),
      .status      (status)
   );

   sle_line_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // Output register load / drain
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      last_in       = last_ff;
      if (pair.valid) begin
         rsp_tvalid_in = 1'b1;
         first_in      = pair.first;
         second_in     = pair.second;
         last_in       = pair.last;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, second_ff, first_ff};
   assign rsp_tlast  = last_ff;

   // Checks
   `ASSERT_IMPLIES(a_idle_fill, status.idle, status.fill < FILL_W'(LINE_BYTES), "full line left unflushed")
   `ASSERT_IMPLIES(a_no_overwrite, pair.valid, !rsp_tvalid_ff || rsp_tready, "pending beat overwritten")
   `ASSERT_NEXT(a_finish_busy, req_tvalid && req_tready && (req_tuser == OP_FINISH), !status.idle, "finish produced no trailer")

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb
   import sle_pkg::*;
();

   // Opcode value the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 185;
   localparam int TEXT_CHARS    = 40;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 60;

   // In typed expectations '|' stands for the CR LF pair
   localparam logic [7:0] TEXT_EOL = 8'h7c;

   localparam logic [CHAR_W-1:0] CH_1 = 7'h31;
   localparam logic [CHAR_W-1:0] CH_5 = 7'h35;
   localparam logic [CHAR_W-1:0] CH_9 = 7'h39;

   localparam logic [8*16-1:0] S0_TEXT = "S00600004844521B";

   typedef struct packed {
      logic [CHAR_W-1:0] first;
      logic [CHAR_W-1:0] second;
      logic              last;
   } char_pair_type;

   // One directed beat; text is zero when the predictor supplies the answer
   typedef struct packed {
      logic [1:0]              opcode;
      logic [15:0]             operand;
      logic [8*TEXT_CHARS-1:0] text;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] operand
   logic [1:0]  req_tuser = '0;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [6:0] char_first, [13:7] char_second, [15:14] zero
   logic        rsp_tlast;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   // S-record writer state as the block should hold it
   logic [7:0]        byte_shadow [LINE_BYTES];
   logic [FILL_W-1:0] line_fill = '0;
   logic [15:0]       line_addr = '0;
   logic [15:0]       s1_total  = '0;
   logic              hdr_done  = 1'b0;
   logic [7:0]        csum      = '0;

   char_pair_type item_pairs[$];
   char_pair_type pending_pairs[$];

   stim_row_type dir_rows [DIRECTED_ROWS];

   srecord_line_emitter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Random backpressure on the character stream
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL srecord_line_emitter");
         $finish;
      end
   end

   function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h41 + {4'h0, nib} - 8'd10;
      end
      return c[CHAR_W-1:0];
   endfunction

   task automatic add_pair(input logic [CHAR_W-1:0] f, input logic [CHAR_W-1:0] s);
      item_pairs.push_back(char_pair_type'{f, s, 1'b0});
   endtask

   // Byte as two hex digits, summed into the record checksum
   task automatic add_byte(input logic [7:0] b);
      add_pair(hex_ascii(b[7:4]), hex_ascii(b[3:0]));
      csum = csum + b;
   endtask

   task automatic add_record_end();
      add_byte(~csum);
      add_pair(CH_CR, CH_LF);
      csum = '0;
   endtask

   // S1 record of the buffered bytes, S0 header ahead of the first one
   task automatic emit_line();
      int i;
      if (!hdr_done) begin
         for (i = 0; i < 8; i++) begin
            add_pair(S0_TEXT[8*(15-2*i) +: CHAR_W], S0_TEXT[8*(14-2*i) +: CHAR_W]);
         end
         add_pair(CH_CR, CH_LF);
         hdr_done = 1'b1;
      end
      csum = '0;
      add_pair(CH_S, CH_1);
      add_byte(8'(line_fill) + 8'd3);
      add_byte(line_addr[15:8]);
      add_byte(line_addr[7:0]);
      for (i = 0; i < int'(line_fill); i++) begin
         add_byte(byte_shadow[i]);
      end
      add_record_end();
      line_addr = line_addr + 16'(line_fill);
      line_fill = '0;
      s1_total  = s1_total + 16'd1;
   endtask

   task automatic emit_short(input logic [CHAR_W-1:0] kind, input logic [15:0] word);
      csum = '0;
      add_pair(CH_S, kind);
      add_byte(8'd3);
      add_byte(word[15:8]);
      add_byte(word[7:0]);
      add_record_end();
   endtask

   // Character pairs caused by one request beat
   task automatic predict_text(input logic [1:0] op, input logic [15:0] operand);
      item_pairs.delete();
      case (op)
         OP_SET_ADDR: begin
            if (int'(line_addr) + int'(line_fill) != int'(operand)) begin
               if (line_fill != 0) emit_line();
               line_addr = operand;
            end
         end
         OP_DATA: begin
            byte_shadow[int'(line_fill)] = operand[7:0];
            line_fill = line_fill + FILL_W'(1);
            if (int'(line_fill) >= LINE_BYTES) emit_line();
         end
         OP_FINISH: begin
            if (line_fill != 0) emit_line();
            emit_short(CH_5, s1_total);
            emit_short(CH_9, operand);
         end
         default: ;
      endcase
   endtask

   // Typed expectation, replaces the predicted pairs of this beat
   task automatic typed_text(input logic [8*TEXT_CHARS-1:0] text);
      logic [7:0] ch;
      logic [7:0] held;
      bit         have_first;
      int         i;
      item_pairs.delete();
      have_first = 1'b0;
      held = '0;
      for (i = TEXT_CHARS - 1; i >= 0; i--) begin
         ch = text[8*i +: 8];
         if (ch == 8'h00) begin
            continue;
         end else if (ch == TEXT_EOL) begin
            add_pair(CH_CR, CH_LF);
         end else if (!have_first) begin
            held = ch;
            have_first = 1'b1;
         end else begin
            add_pair(held[CHAR_W-1:0], ch[CHAR_W-1:0]);
            have_first = 1'b0;
         end
      end
   endtask

   task automatic send_req(input logic [1:0] op, input logic [15:0] operand,
                           input logic [8*TEXT_CHARS-1:0] text);
      char_pair_type p;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= operand;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // beat accepted at this edge
      predict_text(op, operand);
      if (text != '0) typed_text(text);
      if (item_pairs.size() > 0) begin
         p = item_pairs.pop_back();
         p.last = 1'b1;
         item_pairs.push_back(p);
      end
      foreach (item_pairs[k]) pending_pairs.push_back(item_pairs[k]);
   endtask

   // Mostly appended bytes, with continuing and jumping addresses, finishes and unused opcodes mixed in
   task automatic pick_random(output logic [1:0] op, output logic [15:0] operand);
      int r;
      r = $urandom_range(0, 99);
      operand = 16'($urandom);
      if (r < 64) begin
         op = OP_DATA;
      end else if (r < 74) begin
         op = OP_SET_ADDR;
         operand = line_addr + 16'(line_fill);
      end else if (r < 84) begin
         op = OP_SET_ADDR;
      end else if (r < 88) begin
         // near the top of memory so lines run across the wrap
         op = OP_SET_ADDR;
         operand = 16'hfff0 | 16'($urandom_range(0, 15));
      end else if (r < 95) begin
         op = OP_FINISH;
      end else begin
         op = OP_UNUSED;
      end
   endtask

   // Compare each character beat with the oldest expected pair
   always @(posedge clock) begin : rsp_check
      char_pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pairs.size() == 0) begin
            $error("unexpected beat: char_first %h char_second %h",
                   rsp_tdata[6:0], rsp_tdata[13:7]);
            fail_count++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_tdata[6:0] !== want.first) begin
               $error("char_first: expected %h, actual %h", want.first, rsp_tdata[6:0]);
               fail_count++;
            end
            if (rsp_tdata[13:7] !== want.second) begin
               $error("char_second: expected %h, actual %h", want.second, rsp_tdata[13:7]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int          i;
      int          sent;
      logic [1:0]  op;
      logic [15:0] operand;

      dir_rows = '{
         // finish straight after reset: trailer only, no header
         '{OP_FINISH,   16'h0000, "S5030000FC|S9030000FC|"},
         '{OP_UNUSED,   16'hffff, '0},
         '{OP_SET_ADDR, 16'h0000, '0},
         '{OP_SET_ADDR, 16'hffff, '0},
         '{OP_DATA,     16'hffab, '0},
         '{OP_DATA,     16'h0000, '0},
         // 0xffff + 2 does not continue at 0x0001: header, then flush
         '{OP_SET_ADDR, 16'h0001, "S00600004844521B|S105FFFFAB0051|"},
         '{OP_SET_ADDR, 16'h0001, '0},
         '{OP_DATA,     16'h00ff, '0},
         '{OP_DATA,     16'hff00, '0},
         '{OP_DATA,     16'h0080, '0},
         '{OP_DATA,     16'h7f01, '0},
         '{OP_DATA,     16'h55aa, '0},
         '{OP_DATA,     16'haa55, '0},
         '{OP_DATA,     16'h1234, '0},
         '{OP_DATA,     16'h8001, '0},
         '{OP_DATA,     16'h00fe, '0},
         '{OP_DATA,     16'h0010, '0},
         '{OP_DATA,     16'hc3c3, '0},
         '{OP_DATA,     16'h3c3c, '0},
         '{OP_DATA,     16'h0f0f, '0},
         '{OP_DATA,     16'hf0f0, '0},
         '{OP_DATA,     16'h0007, '0},
         // sixteenth byte fills the line
         '{OP_DATA,     16'hffff, '0},
         '{OP_FINISH,   16'hffff, "S5030002FA|S903FFFFFE|"}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct  = 10;
      rsp_stall_pct = 83;
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_req(dir_rows[i].opcode, dir_rows[i].operand, dir_rows[i].text);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == RANDOM_ITEMS / 3) begin
            req_idle_pct  = 83;
            rsp_stall_pct = 10;
         end else if (sent == 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         pick_random(op, operand);
         send_req(op, operand, '0);
         if (op != OP_UNUSED) sent++;
      end
      req_tvalid <= 1'b0;

      while (pending_pairs.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS srecord_line_emitter");
      end else begin
         $display("FAIL srecord_line_emitter");
      end
      $finish;
   end

endmodule
